@@ src/lbsp_pkg.sv @@
// Shared types and constants of the line bar steering controller.
// Used by every other file of the block but lbsp_stream_if; depends on nothing.
package lbsp_pkg;

  localparam int SENSOR_COUNT = 6;
  localparam int SUM_W        = 19;  // signed sum of up to six 17 bit weights
  localparam int PROD_W       = 33;  // 17 x 16 signed product
  localparam int ACC_W        = 36;  // pid plus speed never leaves 35 bits
  localparam int DIV_W        = 32;
  localparam int DIV_CNT_W    = $clog2(DIV_W + 1);
  localparam int STEP_W       = 5;
  localparam int CFG_ADDR_W   = 5;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_TIME,
    OP_SUM,
    OP_DIV_POS,
    OP_POS,
    OP_MUL_P,
    OP_ACC_P,
    OP_MUL_I,
    OP_INT,
    OP_ACC_I,
    OP_MUL_D,
    OP_DIV_D,
    OP_ACC_D,
    OP_OUT
  } op_t;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_NO_ITEM,
    COND_SKIP,
    COND_DIV_BUSY,
    COND_OUT_FULL
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ucode_t;

  typedef struct packed {
    logic item;
    logic skip;
    logic div_busy;
    logic out_full;
  } dp_status_t;

  typedef enum logic [2:0] {
    REG_GAIN_P,
    REG_GAIN_I,
    REG_GAIN_D,
    REG_LOOP_PERIOD_MS,
    REG_DARK_THRESHOLD,
    REG_WEIGHT_INNER,
    REG_WEIGHT_MIDDLE,
    REG_WEIGHT_OUTER
  } reg_idx_t;

  typedef struct packed {
    logic signed [15:0] gain_p;
    logic signed [15:0] gain_i;
    logic signed [15:0] gain_d;
    logic        [15:0] loop_period_ms;
    logic        [11:0] dark_threshold;
    logic signed [15:0] weight_inner;
    logic signed [15:0] weight_middle;
    logic signed [15:0] weight_outer;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    gain_p:         16'sd0,
    gain_i:         16'sd0,
    gain_d:         16'sd0,
    loop_period_ms: 16'd10,
    dark_threshold: 12'd2048,
    weight_inner:   16'sd1024,
    weight_middle:  16'sd3072,
    weight_outer:   16'sd5120
  };

  typedef struct packed {
    logic        [31:0] now_ms;
    logic        [11:0] sample_left_outer;
    logic        [11:0] sample_left_middle;
    logic        [11:0] sample_left_inner;
    logic        [11:0] sample_right_inner;
    logic        [11:0] sample_right_middle;
    logic        [11:0] sample_right_outer;
    logic signed [31:0] speed_setpoint;
  } meas_t;

  typedef struct packed {
    logic signed [31:0] left_wheel_target;
    logic signed [31:0] right_wheel_target;
    logic signed [15:0] line_position;
  } cmd_t;

endpackage

@@ src/lbsp_stream_if.sv @@
// Valid/ready channel used for the measurement and command items.
// The payload type is supplied by the instantiating scope; no dependencies.
interface lbsp_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ src/lbsp_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on lbsp_pkg.
module lbsp_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [lbsp_pkg::DIV_CNT_W-1:0] iters,
  input  logic [lbsp_pkg::DIV_W-1:0]     dividend,
  input  logic [lbsp_pkg::DIV_W-1:0]     divisor,
  output logic                           busy,
  output logic [lbsp_pkg::DIV_W-1:0]     quotient
);
  import lbsp_pkg::*;

  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     quo;
  logic [DIV_W-1:0]     dsr;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W:0]       shifted;
  logic [DIV_W:0]       trial;

  assign shifted  = {rem, quo[DIV_W-1]};
  assign trial    = shifted - {1'b0, dsr};
  assign busy     = (cnt != '0);
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= iters;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  // dividend is left-aligned, so a short run leaves the quotient in the low bits
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      quo <= {quo[DIV_W-2:0], ~trial[DIV_W]};
      rem <= trial[DIV_W] ? shifted[DIV_W-1:0] : trial[DIV_W-1:0];
    end
  end
endmodule

@@ src/lbsp_seq.sv @@
// Microcode sequencer: program ROM, step counter and jump logic.
// Depends on lbsp_pkg; drives the datapath opcode from the current step.
module lbsp_seq (
  input  logic                   clk,
  input  logic                   rst,
  input  lbsp_pkg::dp_status_t   status,
  output lbsp_pkg::op_t          op
);
  import lbsp_pkg::*;

  localparam step_t S_IDLE     = 5'd0;
  localparam step_t S_POS_WAIT = 5'd4;
  localparam step_t S_D_WAIT   = 5'd13;
  localparam step_t S_OUT_WAIT = 5'd15;

  step_t  step;
  ucode_t uc;
  logic   take;

  always_comb begin
    case (step)
      5'd0:    uc = '{OP_LOAD,    COND_NO_ITEM,  S_IDLE};
      5'd1:    uc = '{OP_TIME,    COND_SKIP,     S_IDLE};
      5'd2:    uc = '{OP_SUM,     COND_NEXT,     S_IDLE};
      5'd3:    uc = '{OP_DIV_POS, COND_NEXT,     S_IDLE};
      5'd4:    uc = '{OP_NOP,     COND_DIV_BUSY, S_POS_WAIT};
      5'd5:    uc = '{OP_POS,     COND_NEXT,     S_IDLE};
      5'd6:    uc = '{OP_MUL_P,   COND_NEXT,     S_IDLE};
      5'd7:    uc = '{OP_ACC_P,   COND_NEXT,     S_IDLE};
      5'd8:    uc = '{OP_MUL_I,   COND_NEXT,     S_IDLE};
      5'd9:    uc = '{OP_INT,     COND_NEXT,     S_IDLE};
      5'd10:   uc = '{OP_ACC_I,   COND_NEXT,     S_IDLE};
      5'd11:   uc = '{OP_MUL_D,   COND_NEXT,     S_IDLE};
      5'd12:   uc = '{OP_DIV_D,   COND_NEXT,     S_IDLE};
      5'd13:   uc = '{OP_NOP,     COND_DIV_BUSY, S_D_WAIT};
      5'd14:   uc = '{OP_ACC_D,   COND_NEXT,     S_IDLE};
      5'd15:   uc = '{OP_NOP,     COND_OUT_FULL, S_OUT_WAIT};
      5'd16:   uc = '{OP_OUT,     COND_ALWAYS,   S_IDLE};
      default: uc = '{OP_NOP,     COND_ALWAYS,   S_IDLE};
    endcase
  end

  always_comb begin
    case (uc.cond)
      COND_NEXT:     take = 1'b0;
      COND_ALWAYS:   take = 1'b1;
      COND_NO_ITEM:  take = ~status.item;
      COND_SKIP:     take = status.skip;
      COND_DIV_BUSY: take = status.div_busy;
      COND_OUT_FULL: take = status.out_full;
      default:       take = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_IDLE;
    end else begin
      step <= take ? uc.target : step + 1'b1;
    end
  end

  assign op = uc.op;
endmodule

@@ src/lbsp_datapath.sv @@
// Datapath: item latch, sensor sum, shared multiplier, divider, accumulator,
// controller state and the output register. Depends on lbsp_pkg, lbsp_stream_if, lbsp_div.
module lbsp_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  lbsp_pkg::op_t        op,
  input  lbsp_pkg::cfg_t       cfg,
  lbsp_stream_if.sink          meas,
  lbsp_stream_if.source        cmd,
  output lbsp_pkg::dp_status_t status
);
  import lbsp_pkg::*;

  meas_t                    meas_hold;
  logic [31:0]              last_update_time;
  logic [31:0]              dt;
  logic signed [15:0]       held_position;
  logic signed [15:0]       previous_error;
  logic signed [31:0]       integral_sum;
  logic signed [SUM_W-1:0]  pos_sum;
  logic [2:0]               pos_count;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic                     div_neg;
  cmd_t                     cmd_data;
  logic                     cmd_valid;

  logic [31:0]              dt_now;
  logic [11:0]              samples [SENSOR_COUNT];
  logic signed [SUM_W-1:0]  weights [SENSOR_COUNT];
  logic signed [SUM_W-1:0]  sum_w;
  logic [2:0]               cnt_w;
  logic [SUM_W-1:0]         pos_mag;
  logic signed [16:0]       mul_a;
  logic signed [15:0]       mul_b;
  logic signed [PROD_W-1:0] prod_w;
  logic [PROD_W-1:0]        prod_mag;
  logic signed [ACC_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]  quo_ext;
  logic signed [ACC_W-1:0]  quo_s;
  logic signed [15:0]       pos_sat;
  logic signed [ACC_W-1:0]  speed_ext;

  logic                     div_start;
  logic [DIV_CNT_W-1:0]     div_iters;
  logic [DIV_W-1:0]         div_dividend;
  logic [DIV_W-1:0]         div_divisor;
  logic                     div_busy;
  logic [DIV_W-1:0]         quo;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-32:0] upper;
    upper = v[ACC_W-1:31];
    if (upper == '0 || upper == '1) begin
      sat32 = v[31:0];
    end else if (v[ACC_W-1]) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = 32'sh7FFF_FFFF;
    end
  endfunction

  assign meas.ready  = (op == OP_LOAD);
  assign cmd.valid   = cmd_valid;
  assign cmd.payload = cmd_data;

  // elapsed time wraps modulo 2^32
  assign dt_now = meas_hold.now_ms - last_update_time;

  always_comb begin
    status.item     = meas.valid & meas.ready;
    status.skip     = dt_now < {16'd0, cfg.loop_period_ms};
    status.div_busy = div_busy;
    status.out_full = cmd_valid;
  end

  assign samples[0] = meas_hold.sample_left_outer;
  assign samples[1] = meas_hold.sample_left_middle;
  assign samples[2] = meas_hold.sample_left_inner;
  assign samples[3] = meas_hold.sample_right_inner;
  assign samples[4] = meas_hold.sample_right_middle;
  assign samples[5] = meas_hold.sample_right_outer;

  assign weights[0] = SUM_W'(cfg.weight_outer);
  assign weights[1] = SUM_W'(cfg.weight_middle);
  assign weights[2] = SUM_W'(cfg.weight_inner);
  assign weights[3] = -SUM_W'(cfg.weight_inner);
  assign weights[4] = -SUM_W'(cfg.weight_middle);
  assign weights[5] = -SUM_W'(cfg.weight_outer);

  always_comb begin
    sum_w = '0;
    cnt_w = '0;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      if (samples[i] < cfg.dark_threshold) begin
        sum_w = sum_w + weights[i];
        cnt_w = cnt_w + 3'd1;
      end
    end
  end

  always_comb begin
    case (op)
      OP_MUL_I: begin
        mul_a = 17'(held_position);
        mul_b = cfg.gain_i;
      end
      OP_MUL_D: begin
        mul_a = 17'(held_position) - 17'(previous_error);
        mul_b = cfg.gain_d;
      end
      default: begin
        mul_a = 17'(held_position);
        mul_b = cfg.gain_p;
      end
    endcase
  end

  assign prod_w    = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign prod_q    = ACC_W'(prod >>> 4);  // floor division by 16
  assign prod_mag  = prod[PROD_W-1] ? -prod : prod;
  assign pos_mag   = pos_sum[SUM_W-1] ? SUM_W'(-pos_sum) : pos_sum;
  assign quo_ext   = $signed({{(ACC_W-DIV_W){1'b0}}, quo});
  assign quo_s     = div_neg ? -quo_ext : quo_ext;
  assign speed_ext = ACC_W'(meas_hold.speed_setpoint);

  // signed mean, truncated toward zero and clipped to Q4.12
  always_comb begin
    if (!div_neg) begin
      pos_sat = (quo > 32'd32767) ? 16'sh7FFF : quo[15:0];
    end else begin
      pos_sat = (quo > 32'd32768) ? 16'sh8000 : 16'(~quo[15:0] + 16'd1);
    end
  end

  always_comb begin
    div_start    = 1'b0;
    div_iters    = DIV_CNT_W'(DIV_W);
    div_dividend = prod_mag[DIV_W-1:0];
    div_divisor  = (dt == '0) ? 32'd1 : dt;
    case (op)
      OP_DIV_POS: begin
        div_start    = 1'b1;
        div_iters    = DIV_CNT_W'(SUM_W);
        div_dividend = {pos_mag, {(DIV_W-SUM_W){1'b0}}};
        div_divisor  = 32'(pos_count);
      end
      OP_DIV_D: begin
        div_start = 1'b1;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  lbsp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .iters    (div_iters),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (quo)
  );

  // controller state and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      last_update_time <= '0;
      held_position    <= '0;
      previous_error   <= '0;
      integral_sum     <= '0;
      cmd_valid        <= 1'b0;
    end else begin
      if (cmd_valid && cmd.ready) begin
        cmd_valid <= 1'b0;
      end
      case (op)
        OP_SUM:   last_update_time <= meas_hold.now_ms;
        OP_POS: begin
          if (pos_count != '0) begin
            held_position <= pos_sat;
          end
        end
        OP_INT:   integral_sum <= sat32(ACC_W'(integral_sum) + prod_q);
        OP_MUL_D: previous_error <= held_position;
        OP_OUT:   cmd_valid <= 1'b1;
        default: begin
        end
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        if (meas.valid) begin
          meas_hold <= meas.payload;
        end
      end
      OP_TIME:    dt <= dt_now;
      OP_SUM: begin
        pos_sum   <= sum_w;
        pos_count <= cnt_w;
      end
      OP_DIV_POS: div_neg <= pos_sum[SUM_W-1];
      OP_MUL_P:   prod <= prod_w;
      OP_ACC_P:   acc <= prod_q;
      OP_MUL_I:   prod <= prod_w;
      OP_ACC_I:   acc <= acc + ACC_W'(integral_sum);
      OP_MUL_D:   prod <= prod_w;
      OP_DIV_D:   div_neg <= prod[PROD_W-1];
      OP_ACC_D:   acc <= acc + (quo_s >>> 4);
      OP_OUT: begin
        cmd_data.left_wheel_target  <= sat32(speed_ext + acc);
        cmd_data.right_wheel_target <= sat32(speed_ext - acc);
        cmd_data.line_position      <= held_position;
      end
      default: begin
      end
    endcase
  end
endmodule

@@ src/line_bar_steering_pid.sv @@
// Line bar steering controller: six line sensors in, PID wheel targets out.
// An accepted item whose elapsed time reaches loop_period_ms runs the PID
// update before the next item is taken, mostly in the bit-serial divider
// (19 quotient bits for the mean position, 32 for the derivative over the
// elapsed ms); an item with no update passes only the load and time steps.
// The finished command sits in an output register, so the next item is
// taken while it waits. Registers are written over APB at byte address 4*index.
// Depends on lbsp_pkg, lbsp_stream_if, lbsp_seq, lbsp_datapath, lbsp_div.
module line_bar_steering_pid (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lbsp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  lbsp_stream_if.sink                     meas,
  lbsp_stream_if.source                   cmd
);
  import lbsp_pkg::*;

  cfg_t       cfg;
  reg_idx_t   reg_idx;
  logic       cfg_write;
  op_t        op;
  dp_status_t status;

  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_GAIN_P:         cfg.gain_p         <= pwdata[15:0];
        REG_GAIN_I:         cfg.gain_i         <= pwdata[15:0];
        REG_GAIN_D:         cfg.gain_d         <= pwdata[15:0];
        REG_LOOP_PERIOD_MS: cfg.loop_period_ms <= pwdata[15:0];
        REG_DARK_THRESHOLD: cfg.dark_threshold <= pwdata[11:0];
        REG_WEIGHT_INNER:   cfg.weight_inner   <= pwdata[15:0];
        REG_WEIGHT_MIDDLE:  cfg.weight_middle  <= pwdata[15:0];
        REG_WEIGHT_OUTER:   cfg.weight_outer   <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GAIN_P:         prdata = {16'd0, cfg.gain_p};
      REG_GAIN_I:         prdata = {16'd0, cfg.gain_i};
      REG_GAIN_D:         prdata = {16'd0, cfg.gain_d};
      REG_LOOP_PERIOD_MS: prdata = {16'd0, cfg.loop_period_ms};
      REG_DARK_THRESHOLD: prdata = {20'd0, cfg.dark_threshold};
      REG_WEIGHT_INNER:   prdata = {16'd0, cfg.weight_inner};
      REG_WEIGHT_MIDDLE:  prdata = {16'd0, cfg.weight_middle};
      REG_WEIGHT_OUTER:   prdata = {16'd0, cfg.weight_outer};
      default:            prdata = '0;
    endcase
  end

  lbsp_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .op     (op)
  );

  lbsp_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .op     (op),
    .cfg    (cfg),
    .meas   (meas),
    .cmd    (cmd),
    .status (status)
  );
endmodule
